>>> sv/av1_obu_stream_splitter_defines.svh
// Assertion macros for the OBU stream splitter checker.
// Each macro expects signals named clk and arst_n in the scope where it is used.
`ifndef AV1_OBU_STREAM_SPLITTER_DEFINES_SVH
`define AV1_OBU_STREAM_SPLITTER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define OBUSS_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("obuss: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define OBUSS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("obuss: next-cycle check failed");

`endif

>>> sv/obuss_pkg.sv
// Shared types and constants of the OBU stream splitter.
// No dependencies; the modules and the checker refer to it by scoped names.
package obuss_pkg;

	// Sizing of offsets and of the LEB128 size field.
	localparam int OFFSET_WIDTH   = 24;
	localparam int MAX_SIZE_BYTES = 8;
	localparam int ACC_WIDTH      = 7 * MAX_SIZE_BYTES;
	localparam int CNT_WIDTH      = $clog2(MAX_SIZE_BYTES + 1);
	localparam int CMP_WIDTH      = (ACC_WIDTH > OFFSET_WIDTH) ? ACC_WIDTH : OFFSET_WIDTH;

	localparam logic [OFFSET_WIDTH-1:0] OFS_ONE  = OFFSET_WIDTH'(1);
	localparam logic [CNT_WIDTH-1:0]    CNT_ONE  = CNT_WIDTH'(1);
	localparam logic [CNT_WIDTH-1:0]    CNT_MAX  = CNT_WIDTH'(MAX_SIZE_BYTES);

	// OBU type codes that the parser looks at.
	localparam logic [3:0] OBU_TYPE_RSVD0      = 4'd0;
	localparam logic [3:0] OBU_SEQ_HDR         = 4'd1;
	localparam logic [3:0] OBU_TEMPORAL_DELIM  = 4'd2;
	localparam logic [3:0] OBU_FRAME_HDR       = 4'd3;
	localparam logic [3:0] OBU_FRAME           = 4'd6;
	localparam logic [3:0] OBU_RSVD_LO         = 4'd9;
	localparam logic [3:0] OBU_RSVD_HI         = 4'd14;

	// Descriptor status codes.
	typedef enum logic [3:0] {
		ST_OK            = 4'd0,
		ST_FORBIDDEN     = 4'd1,
		ST_RSVD_TYPE     = 4'd2,
		ST_RSVD_BIT      = 4'd3,
		ST_EXT_RSVD      = 4'd4,
		ST_LEB_LONG      = 4'd5,
		ST_TRUNCATED     = 4'd6,
		ST_TOO_BIG       = 4'd7,
		ST_END_AFTER_ERR = 4'd8
	} status_t;

	// Parser phase, one-hot.
	typedef enum logic [5:0] {
		PH_HEADER  = 6'b000001,
		PH_EXT     = 6'b000010,
		PH_SIZE    = 6'b000100,
		PH_PAYLOAD = 6'b001000,
		PH_TO_END  = 6'b010000,
		PH_DISCARD = 6'b100000
	} phase_t;

	// Header fields kept for the current OBU.
	typedef struct packed {
		logic [3:0] typ;
		logic       ext;
		logic       szf;
		logic [2:0] tid;
		logic [1:0] sid;
	} hdr_t;

	// One input transaction.
	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} item_t;

	// One OBU descriptor.
	typedef struct packed {
		logic [3:0]              obu_kind;
		logic                    has_extension;
		logic                    size_present;
		logic [2:0]              temporal_layer;
		logic [1:0]              spatial_layer;
		logic [OFFSET_WIDTH-1:0] obu_start;
		logic [OFFSET_WIDTH-1:0] payload_start;
		logic [OFFSET_WIDTH-1:0] payload_length;
		logic                    is_key;
		status_t                 status;
		logic                    end_of_buffer;
	} desc_t;

	// Handshake between the parser and the input register.
	typedef struct packed {
		logic valid;
		item_t item;
	} s1_bus_t;

endpackage

>>> sv/obuss_in_stage.sv
// Input register of the OBU stream splitter: holds one byte transaction for the parser.
// Depends on obuss_pkg.
module obuss_in_stage (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [7:0]        data_byte,
	input  logic              last_byte,
	input  logic              adv,
	output obuss_pkg::s1_bus_t s1_bus
);

	logic            valid_s1;
	obuss_pkg::item_t item_s1;
	logic            take;

	// The register frees up in the same cycle the parser consumes its byte.
	assign in_stall = valid_s1 & ~adv;
	assign take     = in_valid & ~in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	// Payload needs no reset.
	always_ff @(posedge clk) begin
		if (take) begin
			item_s1.data_byte <= data_byte;
			item_s1.last_byte <= last_byte;
		end
	end

	assign s1_bus.valid = valid_s1;
	assign s1_bus.item  = item_s1;

endmodule

>>> sv/obuss_parser.sv
// Byte-level OBU parser: header checks, LEB128 size decode, payload counting.
// Depends on obuss_pkg. Builds at most one descriptor per byte.
module obuss_parser (
	input  logic               clk,
	input  logic               arst_n,
	input  obuss_pkg::s1_bus_t s1_bus,
	input  logic               out_free,
	output logic               adv,
	output logic               res_valid,
	output obuss_pkg::desc_t   res
);

	localparam int OW = obuss_pkg::OFFSET_WIDTH;

	obuss_pkg::phase_t                 phase_q, phase_n;
	logic [OW-1:0]                     byte_pos_q, byte_pos_n;
	logic [OW-1:0]                     obu_start_q, obu_start_n;
	logic [OW-1:0]                     pl_start_q, pl_start_n;
	obuss_pkg::hdr_t                   hdr_q, hdr_n, hdr_tmp;
	logic [obuss_pkg::ACC_WIDTH-1:0]   acc_q, acc_n;
	logic [obuss_pkg::CNT_WIDTH-1:0]   cnt_q, cnt_n, cnt_inc;
	logic [OW-1:0]                     remain_q, remain_n;
	logic [OW-1:0]                     plen_q, plen_n;
	logic                              first_q, first_n;
	logic [7:0]                        fpb_q, fpb_n;
	logic                              reduced_q, reduced_n, reduced_upd;
	logic [obuss_pkg::CMP_WIDTH-1:0]   acc_ext, room;
	logic [OW-1:0]                     ps_next, obu_len;
	logic                              do_err, do_obu, ah_go, key;
	obuss_pkg::status_t                err_code;
	logic [7:0]                        b;
	logic                              last;

	assign b    = s1_bus.item.data_byte;
	assign last = s1_bus.item.last_byte;

	always_comb begin
		phase_n     = phase_q;
		byte_pos_n  = byte_pos_q;
		obu_start_n = obu_start_q;
		pl_start_n  = pl_start_q;
		hdr_n       = hdr_q;
		acc_n       = acc_q;
		cnt_n       = cnt_q;
		remain_n    = remain_q;
		plen_n      = plen_q;
		first_n     = first_q;
		fpb_n       = fpb_q;
		reduced_n   = reduced_q;
		reduced_upd = reduced_q;
		do_err      = 1'b0;
		do_obu      = 1'b0;
		ah_go       = 1'b0;
		key         = 1'b0;
		err_code    = obuss_pkg::ST_OK;
		obu_len     = '0;
		cnt_inc     = cnt_q + obuss_pkg::CNT_ONE;
		ps_next     = byte_pos_q + obuss_pkg::OFS_ONE;
		hdr_tmp     = '0;
		acc_ext     = '0;
		room        = '0;
		res         = '0;

		// Per-phase handling of the current byte.
		case (phase_q)
			obuss_pkg::PH_HEADER: begin
				obu_start_n = byte_pos_q;
				hdr_tmp.typ = b[6:3];
				hdr_tmp.ext = b[2];
				hdr_tmp.szf = b[1];
				if (b[7]) begin
					do_err   = 1'b1;
					err_code = obuss_pkg::ST_FORBIDDEN;
				end else if (hdr_tmp.typ == obuss_pkg::OBU_TYPE_RSVD0 ||
						(hdr_tmp.typ >= obuss_pkg::OBU_RSVD_LO &&
						 hdr_tmp.typ <= obuss_pkg::OBU_RSVD_HI)) begin
					do_err   = 1'b1;
					err_code = obuss_pkg::ST_RSVD_TYPE;
				end else if (b[0]) begin
					do_err   = 1'b1;
					err_code = obuss_pkg::ST_RSVD_BIT;
				end else begin
					hdr_n = hdr_tmp;
					if (hdr_tmp.ext) begin
						if (last) begin
							do_err   = 1'b1;
							err_code = obuss_pkg::ST_TRUNCATED;
						end else begin
							phase_n = obuss_pkg::PH_EXT;
						end
					end else begin
						ah_go = 1'b1;
					end
				end
			end
			obuss_pkg::PH_EXT: begin
				if (b[2:0] != 3'b000) begin
					do_err   = 1'b1;
					err_code = obuss_pkg::ST_EXT_RSVD;
				end else begin
					hdr_n.tid = b[7:5];
					hdr_n.sid = b[4:3];
					ah_go     = 1'b1;
				end
			end
			obuss_pkg::PH_SIZE: begin
				// Drop the seven value bits into their slot of the accumulator.
				for (int k = 0; k < obuss_pkg::MAX_SIZE_BYTES; k++) begin
					if (cnt_q == obuss_pkg::CNT_WIDTH'(k)) begin
						acc_n[7*k +: 7] = acc_q[7*k +: 7] | b[6:0];
					end
				end
				cnt_n = cnt_inc;
				if (b[7]) begin
					if (cnt_inc >= obuss_pkg::CNT_MAX) begin
						do_err   = 1'b1;
						err_code = obuss_pkg::ST_LEB_LONG;
					end else if (last) begin
						do_err   = 1'b1;
						err_code = obuss_pkg::ST_TRUNCATED;
					end
				end else begin
					pl_start_n = ps_next;
					// The payload must end at or below the largest offset.
					acc_ext = obuss_pkg::CMP_WIDTH'(acc_n);
					room    = {{(obuss_pkg::CMP_WIDTH - OW){1'b0}}, ~ps_next};
					if (acc_ext > room) begin
						do_err   = 1'b1;
						err_code = obuss_pkg::ST_TOO_BIG;
					end else begin
						fpb_n = '0;
						if (acc_n == '0) begin
							do_obu  = 1'b1;
							obu_len = '0;
						end else if (last) begin
							do_err   = 1'b1;
							err_code = obuss_pkg::ST_TOO_BIG;
						end else begin
							remain_n = acc_ext[OW-1:0];
							plen_n   = acc_ext[OW-1:0];
							first_n  = 1'b1;
							phase_n  = obuss_pkg::PH_PAYLOAD;
						end
					end
				end
			end
			obuss_pkg::PH_PAYLOAD: begin
				if (first_q) begin
					fpb_n = b;
				end
				first_n  = 1'b0;
				remain_n = remain_q - obuss_pkg::OFS_ONE;
				if (remain_n == '0) begin
					do_obu  = 1'b1;
					obu_len = plen_q;
				end else if (last) begin
					do_err   = 1'b1;
					err_code = obuss_pkg::ST_TOO_BIG;
				end
			end
			obuss_pkg::PH_TO_END: begin
				if (byte_pos_q == pl_start_q) begin
					fpb_n = b;
				end
				if (last) begin
					do_obu  = 1'b1;
					obu_len = byte_pos_q - pl_start_q + obuss_pkg::OFS_ONE;
				end
			end
			obuss_pkg::PH_DISCARD: begin
				if (last) begin
					do_err   = 1'b1;
					err_code = obuss_pkg::ST_END_AFTER_ERR;
				end
			end
			default: begin
				phase_n = obuss_pkg::PH_DISCARD;
			end
		endcase

		// Header complete: size field, buffer end, finish, or a truncation error.
		if (ah_go) begin
			pl_start_n = ps_next;
			if (hdr_n.szf) begin
				if (last) begin
					do_err   = 1'b1;
					err_code = obuss_pkg::ST_TRUNCATED;
				end else begin
					phase_n = obuss_pkg::PH_SIZE;
					acc_n   = '0;
					cnt_n   = '0;
				end
			end else begin
				fpb_n = '0;
				if (hdr_n.typ == obuss_pkg::OBU_TEMPORAL_DELIM || last) begin
					do_obu  = 1'b1;
					obu_len = '0;
				end else begin
					phase_n = obuss_pkg::PH_TO_END;
				end
			end
		end

		// Descriptor assembly.
		if (do_obu) begin
			if (hdr_n.typ == obuss_pkg::OBU_SEQ_HDR && obu_len != '0) begin
				reduced_upd = fpb_n[3];
			end
			key = (hdr_n.typ == obuss_pkg::OBU_FRAME_HDR || hdr_n.typ == obuss_pkg::OBU_FRAME) &&
				(reduced_upd || (obu_len != '0 && !fpb_n[7] && fpb_n[6:5] == 2'b00));
			reduced_n          = reduced_upd;
			phase_n            = obuss_pkg::PH_HEADER;
			res.obu_kind       = hdr_n.typ;
			res.has_extension  = hdr_n.ext;
			res.size_present   = hdr_n.szf;
			res.temporal_layer = hdr_n.tid;
			res.spatial_layer  = hdr_n.sid;
			res.obu_start      = obu_start_n;
			res.payload_start  = pl_start_n;
			res.payload_length = obu_len;
			res.is_key         = key;
			res.status         = obuss_pkg::ST_OK;
		end else if (do_err) begin
			phase_n    = obuss_pkg::PH_DISCARD;
			res.status = err_code;
			res.obu_start = (err_code == obuss_pkg::ST_END_AFTER_ERR) ? '0 : obu_start_n;
		end
		res.end_of_buffer = last;

		// The last byte restarts the buffer.
		if (last) begin
			phase_n    = obuss_pkg::PH_HEADER;
			byte_pos_n = '0;
			reduced_n  = 1'b0;
		end else begin
			byte_pos_n = ps_next;
		end
	end

	assign res_valid = s1_bus.valid & (do_obu | do_err);
	assign adv       = s1_bus.valid & (~(do_obu | do_err) | out_free);

	// Parser state advances once per consumed byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= obuss_pkg::PH_HEADER;
			byte_pos_q  <= '0;
			obu_start_q <= '0;
			pl_start_q  <= '0;
			hdr_q       <= '0;
			acc_q       <= '0;
			cnt_q       <= '0;
			remain_q    <= '0;
			plen_q      <= '0;
			first_q     <= 1'b0;
			fpb_q       <= '0;
			reduced_q   <= 1'b0;
		end else if (adv) begin
			phase_q     <= phase_n;
			byte_pos_q  <= byte_pos_n;
			obu_start_q <= obu_start_n;
			pl_start_q  <= pl_start_n;
			hdr_q       <= hdr_n;
			acc_q       <= acc_n;
			cnt_q       <= cnt_n;
			remain_q    <= remain_n;
			plen_q      <= plen_n;
			first_q     <= first_n;
			fpb_q       <= fpb_n;
			reduced_q   <= reduced_n;
		end
	end

endmodule

>>> sv/obuss_out_reg.sv
// Output register of the OBU stream splitter: holds one descriptor until it is taken.
// Depends on obuss_pkg.
module obuss_out_reg (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             res_valid,
	input  logic             adv,
	input  obuss_pkg::desc_t res,
	input  logic             out_stall,
	output logic             out_free,
	output logic             out_valid,
	output obuss_pkg::desc_t desc_q
);

	logic valid_q;
	logic load;

	// Free when empty or when the held descriptor is taken this cycle.
	assign out_free = ~valid_q | ~out_stall;
	assign load     = res_valid & adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (out_free) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			desc_q <= res;
		end
	end

	assign out_valid = valid_q;

endmodule

>>> sv/av1_obu_stream_splitter.sv
// AV1 OBU stream splitter: takes one buffer byte per transaction and returns one
// descriptor per OBU, or an error status. A byte is taken every clock unless the input
// stalls; the parser reads the input register and loads each descriptor into the output
// register. The rate is set by the combinational parser update, which includes the LEB128
// accumulate and the payload range compare. The two registers separate the two channels,
// so bytes keep flowing while a finished descriptor waits; the input stalls only when the
// next byte completes a second descriptor before the first is taken.
// Depends on obuss_pkg, obuss_in_stage, obuss_parser and obuss_out_reg.
module av1_obu_stream_splitter (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [7:0]                           data_byte,
	input  logic                                 last_byte,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [3:0]                           obu_kind,
	output logic                                 has_extension,
	output logic                                 size_present,
	output logic [2:0]                           temporal_layer,
	output logic [1:0]                           spatial_layer,
	output logic [obuss_pkg::OFFSET_WIDTH-1:0]   obu_start,
	output logic [obuss_pkg::OFFSET_WIDTH-1:0]   payload_start,
	output logic [obuss_pkg::OFFSET_WIDTH-1:0]   payload_length,
	output logic                                 is_key,
	output logic [3:0]                           status,
	output logic                                 end_of_buffer
);

	obuss_pkg::s1_bus_t s1_bus;
	obuss_pkg::desc_t   res;
	obuss_pkg::desc_t   desc_q;
	logic               adv;
	logic               res_valid;
	logic               out_free;

	obuss_in_stage u_in_stage (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.data_byte (data_byte),
		.last_byte (last_byte),
		.adv       (adv),
		.s1_bus    (s1_bus)
	);

	obuss_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.s1_bus    (s1_bus),
		.out_free  (out_free),
		.adv       (adv),
		.res_valid (res_valid),
		.res       (res)
	);

	obuss_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (res_valid),
		.adv       (adv),
		.res       (res),
		.out_stall (out_stall),
		.out_free  (out_free),
		.out_valid (out_valid),
		.desc_q    (desc_q)
	);

	// Descriptor fields onto their ports.
	assign obu_kind       = desc_q.obu_kind;
	assign has_extension  = desc_q.has_extension;
	assign size_present   = desc_q.size_present;
	assign temporal_layer = desc_q.temporal_layer;
	assign spatial_layer  = desc_q.spatial_layer;
	assign obu_start      = desc_q.obu_start;
	assign payload_start  = desc_q.payload_start;
	assign payload_length = desc_q.payload_length;
	assign is_key         = desc_q.is_key;
	assign status         = desc_q.status;
	assign end_of_buffer  = desc_q.end_of_buffer;

endmodule

>>> sv/obuss_checker.sv
// Port-level checks on the OBU stream splitter's descriptor channel, and its bind.
// Depends on obuss_pkg and av1_obu_stream_splitter_defines.svh.
`include "av1_obu_stream_splitter_defines.svh"

module obuss_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               out_valid,
	input logic                               out_stall,
	input logic [3:0]                         obu_kind,
	input logic                               has_extension,
	input logic [2:0]                         temporal_layer,
	input logic [1:0]                         spatial_layer,
	input logic [obuss_pkg::OFFSET_WIDTH-1:0] obu_start,
	input logic [obuss_pkg::OFFSET_WIDTH-1:0] payload_length,
	input logic                               is_key,
	input logic [3:0]                         status,
	input logic                               end_of_buffer
);

	// A stalled descriptor holds.
	`OBUSS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(obu_start) && $stable(status))

	// An error descriptor carries no OBU content.
	`OBUSS_ASSERT_NOW(a_err_clear, out_valid && status != obuss_pkg::ST_OK, obu_kind == obuss_pkg::OBU_TYPE_RSVD0 && payload_length == '0 && is_key == 1'b0)

	// The discard-end status only closes a buffer and carries no offset.
	`OBUSS_ASSERT_NOW(a_end_err, out_valid && status == obuss_pkg::ST_END_AFTER_ERR, end_of_buffer && obu_start == '0)

	// Key frames are flagged only on frame and frame-header OBUs.
	`OBUSS_ASSERT_NOW(a_key_type, out_valid && is_key, status == obuss_pkg::ST_OK && (obu_kind == obuss_pkg::OBU_FRAME_HDR || obu_kind == obuss_pkg::OBU_FRAME))

	// Layer ids are zero without an extension byte.
	`OBUSS_ASSERT_NOW(a_noext_ids, out_valid && !has_extension, temporal_layer == 3'd0 && spatial_layer == 2'd0)

endmodule

bind av1_obu_stream_splitter obuss_checker u_obuss_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.out_valid      (out_valid),
	.out_stall      (out_stall),
	.obu_kind       (obu_kind),
	.has_extension  (has_extension),
	.temporal_layer (temporal_layer),
	.spatial_layer  (spatial_layer),
	.obu_start      (obu_start),
	.payload_length (payload_length),
	.is_key         (is_key),
	.status         (status),
	.end_of_buffer  (end_of_buffer)
);
